FILE: hdl/image_brightness_statistics_defines.svh
// Assertion macros shared by the brightness statistics RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef IMAGE_BRIGHTNESS_STATISTICS_DEFINES_SVH
`define IMAGE_BRIGHTNESS_STATISTICS_DEFINES_SVH

`ifndef SYNTHESIS
`define IBS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ibs assertion failed");
`define IBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ibs assertion failed");
`else
`define IBS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define IBS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: hdl/ibs_pkg.sv
// Types, widths and constants for the brightness statistics block.
// No dependencies; imported by every other SystemVerilog source but the macro header.
package ibs_pkg;

   localparam int unsigned PIXEL_W    = 8;
   localparam int unsigned LEVELS     = 256;
   localparam int unsigned DISTINCT_W = 9;
   localparam int unsigned COUNT_W    = 25;
   localparam int unsigned SUM_W      = 32;
   localparam int unsigned STEP_W     = 3;
   localparam int unsigned MAX_PIXELS = 16777216;

   typedef logic [PIXEL_W-1:0]    pixel_type;
   typedef logic [DISTINCT_W-1:0] distinct_type;
   typedef logic [COUNT_W-1:0]    count_type;
   typedef logic [SUM_W-1:0]      sum_type;
   typedef logic [STEP_W-1:0]     step_type;

   localparam count_type COUNT_LIMIT = COUNT_W'(MAX_PIXELS);
   localparam step_type  STEP_FIRST  = '1;

   typedef struct packed {
      logic     accum;
      logic     update;
      logic     clear;
      logic     map_clear;
      logic     div_load;
      logic     div_step;
      step_type step;
      logic     load_out;
   } ibs_cmd_type;

   typedef struct packed {
      pixel_type    min_level;
      pixel_type    max_level;
      pixel_type    mean_level;
      distinct_type level_count;
      count_type    pixel_total;
      sum_type      brightness_sum;
      logic         overflow;
   } ibs_result_type;

endpackage

FILE: hdl/ibs_channels.sv
// Valid/ready channel interfaces for pixel input and statistics output words.
// Depends on ibs_pkg.
interface ibs_req_if
   import ibs_pkg::*;
();
   logic      valid;
   logic      ready;
   pixel_type pixel;
   logic      last;

   modport source (output valid, output pixel, output last, input ready);
   modport sink   (input valid, input pixel, input last, output ready);
endinterface

interface ibs_rsp_if
   import ibs_pkg::*;
();
   logic         valid;
   logic         ready;
   pixel_type    min_level;
   pixel_type    max_level;
   pixel_type    mean_level;
   distinct_type level_count;
   count_type    pixel_total;
   sum_type      brightness_sum;
   logic         overflow;

   modport source (output valid, output min_level, output max_level, output mean_level,
                   output level_count, output pixel_total, output brightness_sum,
                   output overflow, input ready);
   modport sink   (input valid, input min_level, input max_level, input mean_level,
                   input level_count, input pixel_total, input brightness_sum,
                   input overflow, output ready);
endinterface

FILE: hdl/image_brightness_statistics.sv
// Per-frame brightness statistics over a pixel stream.
// req_bus: one pixel word per handshake (valid & ready), last marks the frame's final pixel.
// rsp_bus: one result word per frame: min, max, truncated mean, distinct levels,
//   pixel count (saturating at 2^24), brightness sum and a count overflow flag.
// Input: each accepted pixel is followed by a level map update before the next is accepted.
//   After the last pixel, req_ready stays low through 1 update, 1 load,
//   8 restoring divide steps, 1 finish and a level map clearing pass over all 256 levels.
// Output: the result word is registered and becomes valid when the finish step loads it.
// Stall: the result sits in an output register while the next frame streams in;
//   only if that frame ends before the receiver takes the word does the block
//   hold in its finish step, with input paused, until rsp ready.
// Pixels beyond 2^24 in a frame only set the overflow flag.
// Reset (synchronous, active high) clears the statistics; the level map is then
//   cleared by a pass over all 256 levels, and only then does req_ready rise.
// Depends on ibs_pkg, ibs_channels, ibs_ctrl and ibs_datapath.
module image_brightness_statistics
   import ibs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   ibs_req_if.sink   req_bus,
   ibs_rsp_if.source rsp_bus
);

   ibs_cmd_type    cmd;
   ibs_result_type result;
   logic           req_ready;
   logic           rsp_valid;
   logic           map_done;

   ibs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_last  (req_bus.last),
      .req_ready (req_ready),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_valid),
      .map_done  (map_done),
      .cmd       (cmd)
   );

   ibs_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .pixel    (req_bus.pixel),
      .map_done (map_done),
      .result   (result)
   );

   assign req_bus.ready          = req_ready;
   assign rsp_bus.valid          = rsp_valid;
   assign rsp_bus.min_level      = result.min_level;
   assign rsp_bus.max_level      = result.max_level;
   assign rsp_bus.mean_level     = result.mean_level;
   assign rsp_bus.level_count    = result.level_count;
   assign rsp_bus.pixel_total    = result.pixel_total;
   assign rsp_bus.brightness_sum = result.brightness_sum;
   assign rsp_bus.overflow       = result.overflow;

endmodule

FILE: hdl/ibs_datapath.sv
// Statistics datapath: accumulators, level map memory, 8-step mean divider, result register.
// Depends on ibs_pkg and the assertion macro header; driven by ibs_ctrl commands.
`include "image_brightness_statistics_defines.svh"

module ibs_datapath
   import ibs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  ibs_cmd_type    cmd,
   input  pixel_type      pixel,
   output logic           map_done,
   output ibs_result_type result
);

   pixel_type          min_ff;
   pixel_type          max_ff;
   sum_type            sum_ff;
   count_type          count_ff;
   distinct_type       distinct_ff;
   logic               ovf_ff;
   logic               seen_mem [LEVELS];
   logic               seen_rd_ff;
   pixel_type          pix_ff;
   pixel_type          clr_addr_ff;
   sum_type            rem_ff;
   pixel_type          quot_ff;
   ibs_result_type     result_ff;
   sum_type            divisor;
   logic               at_limit;

   assign divisor  = SUM_W'(count_ff) << cmd.step;
   assign at_limit = (count_ff == COUNT_LIMIT);
   assign map_done = (clr_addr_ff == '1);

   // level map: read at accept, written in the following update cycle
   always_ff @(posedge clock) begin
      if (cmd.map_clear) begin
         seen_mem[clr_addr_ff] <= 1'b0;
      end else if (cmd.update && !seen_rd_ff && !at_limit) begin
         seen_mem[pix_ff] <= 1'b1;
      end
      if (cmd.accum) begin
         seen_rd_ff <= seen_mem[pixel];
         pix_ff     <= pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.map_clear) begin
         clr_addr_ff <= clr_addr_ff + PIXEL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         min_ff      <= '1;
         max_ff      <= '0;
         sum_ff      <= '0;
         count_ff    <= '0;
         distinct_ff <= '0;
         ovf_ff      <= 1'b0;
      end else if (cmd.update) begin
         if (at_limit) begin
            ovf_ff <= 1'b1;
         end else begin
            if (pix_ff < min_ff) begin
               min_ff <= pix_ff;
            end
            if (pix_ff > max_ff) begin
               max_ff <= pix_ff;
            end
            sum_ff   <= sum_ff + SUM_W'(pix_ff);
            count_ff <= count_ff + COUNT_W'(1);
            if (!seen_rd_ff) begin
               distinct_ff <= distinct_ff + DISTINCT_W'(1);
            end
         end
      end
   end

   // restoring divide; quotient fits 8 bits since sum < 256 * count
   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff  <= sum_ff;
         quot_ff <= '0;
      end else if (cmd.div_step && (rem_ff >= divisor)) begin
         rem_ff            <= rem_ff - divisor;
         quot_ff[cmd.step] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         result_ff.min_level      <= min_ff;
         result_ff.max_level      <= max_ff;
         result_ff.mean_level     <= quot_ff;
         result_ff.level_count    <= distinct_ff;
         result_ff.pixel_total    <= count_ff;
         result_ff.brightness_sum <= sum_ff;
         result_ff.overflow       <= ovf_ff;
      end
   end

   assign result = result_ff;

   `IBS_ASSERT_IMPL(a_min_le_max, clock, reset, count_ff != '0, min_ff <= max_ff)
   `IBS_ASSERT_IMPL(a_distinct_le_count, clock, reset, 1'b1, COUNT_W'(distinct_ff) <= count_ff)
   `IBS_ASSERT_NEXT(a_clear_empties, clock, reset, cmd.clear, count_ff == '0 && !ovf_ff)

endmodule

FILE: hdl/ibs_ctrl.sv
// Frame controller: accepts pixels, sequences the mean divide, hands off result words.
// Depends on ibs_pkg and the assertion macro header; drives ibs_datapath.
`include "image_brightness_statistics_defines.svh"

module ibs_ctrl
   import ibs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_last,
   output logic        req_ready,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   input  logic        map_done,
   output ibs_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_ACCUM,
      ST_UPDATE,
      ST_LOAD,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type state_ff;
   step_type  step_ff;
   logic      last_ff;
   logic      rsp_valid_ff;
   logic      req_fire;
   logic      out_free;

   assign req_ready = (state_ff == ST_ACCUM);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd           = '0;
      cmd.accum     = req_fire;
      cmd.update    = (state_ff == ST_UPDATE);
      cmd.map_clear = (state_ff == ST_CLEAR);
      cmd.div_load  = (state_ff == ST_LOAD);
      cmd.div_step  = (state_ff == ST_DIVIDE);
      cmd.step      = step_ff;
      cmd.load_out  = (state_ff == ST_FINISH) && out_free;
      cmd.clear     = cmd.load_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= STEP_FIRST;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_FINISH) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               if (map_done) begin
                  state_ff <= ST_ACCUM;
               end
            end
            ST_ACCUM: begin
               if (req_fire) begin
                  last_ff  <= req_last;
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               if (last_ff) begin
                  state_ff <= ST_LOAD;
               end else begin
                  state_ff <= ST_ACCUM;
               end
            end
            ST_LOAD: begin
               step_ff  <= STEP_FIRST;
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               if (step_ff == '0) begin
                  state_ff <= ST_FINISH;
               end else begin
                  step_ff <= step_ff - STEP_W'(1);
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  state_ff <= ST_CLEAR;
               end
            end
            default: begin
               state_ff <= ST_CLEAR;
            end
         endcase
      end
   end

   `IBS_ASSERT_NEXT(a_last_stops_input, clock, reset, req_fire && req_last, !req_ready)
   `IBS_ASSERT_NEXT(a_divide_ends, clock, reset, state_ff == ST_DIVIDE && step_ff == '0, state_ff == ST_FINISH)
   `IBS_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid_ff && !rsp_ready, rsp_valid_ff)

endmodule

FILE: tb/tb_image_brightness_statistics.sv
`timescale 1ns / 100ps
// Self-checking testbench for image_brightness_statistics: streams pixel frames and
// checks each frame's statistics word against a predictor held in a scoreboard class.
// Depends on ibs_pkg, ibs_channels and the image_brightness_statistics RTL.
module tb_image_brightness_statistics
   import ibs_pkg::*;
();

   localparam int unsigned QUIET_LIMIT = 5000;
   localparam int unsigned HOLD_CYCLES = 1000;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned PHASE_WORDS = 225;
   localparam int unsigned PHASE_FRAMES = 15;

   typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_mode_type;

   class frame_stats_scoreboard;
      pixel_type      frame_min;
      pixel_type      frame_max;
      sum_type        frame_sum;
      count_type      frame_count;
      bit [LEVELS-1:0] levels_hit;
      distinct_type   distinct;
      bit             frame_overflow;
      ibs_result_type expected_frames[$];
      int unsigned    errors;

      function new();
         errors = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         frame_min      = '1;
         frame_max      = '0;
         frame_sum      = '0;
         frame_count    = '0;
         levels_hit     = '0;
         distinct       = '0;
         frame_overflow = 1'b0;
      endfunction

      function void take_pixel(pixel_type p, logic last);
         ibs_result_type stats;
         if (frame_count >= COUNT_LIMIT) begin
            frame_overflow = 1'b1;
         end else begin
            if (p < frame_min) frame_min = p;
            if (p > frame_max) frame_max = p;
            frame_sum   = frame_sum + sum_type'(p);
            frame_count = frame_count + COUNT_W'(1);
            if (!levels_hit[p]) begin
               levels_hit[p] = 1'b1;
               distinct      = distinct + DISTINCT_W'(1);
            end
         end
         if (last) begin
            stats.min_level      = frame_min;
            stats.max_level      = frame_max;
            stats.mean_level     = (frame_count != 0) ?
                                   pixel_type'(frame_sum / sum_type'(frame_count)) : '0;
            stats.level_count    = distinct;
            stats.pixel_total    = frame_count;
            stats.brightness_sum = frame_sum;
            stats.overflow       = frame_overflow;
            expected_frames.push_back(stats);
            clear_frame();
         end
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_frame_result(ibs_result_type got);
         ibs_result_type want;
         if (expected_frames.size() == 0) begin
            $error("result word with no frame pending");
            errors++;
         end else begin
            want = expected_frames.pop_front();
            check_field("min_level", 32'(want.min_level), 32'(got.min_level));
            check_field("max_level", 32'(want.max_level), 32'(got.max_level));
            check_field("mean_level", 32'(want.mean_level), 32'(got.mean_level));
            check_field("level_count", 32'(want.level_count), 32'(got.level_count));
            check_field("pixel_total", 32'(want.pixel_total), 32'(got.pixel_total));
            check_field("brightness_sum", 32'(want.brightness_sum),
                        32'(got.brightness_sum));
            check_field("overflow", 32'(want.overflow), 32'(got.overflow));
         end
      endfunction

      function int unsigned pending();
         return expected_frames.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   ibs_req_if req_bus();
   ibs_rsp_if rsp_bus();

   image_brightness_statistics DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   frame_stats_scoreboard frame_stats = new();
   idle_mode_type idle_mode = IDLE_NONE;
   bit            rsp_hold_req = 1'b0;
   int unsigned   sent_words;
   int unsigned   quiet_cycles = 0;
   ibs_result_type got_word;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit sender_gap();
      case (idle_mode)
         IDLE_SENDER: return $urandom_range(99) < 77;
         IDLE_BOTH:   return $urandom_range(99) < 11;
         default:     return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stall();
      case (idle_mode)
         IDLE_RECEIVER: return $urandom_range(99) < 77;
         IDLE_BOTH:     return $urandom_range(99) < 11;
         default:       return 1'b0;
      endcase
   endfunction

   // monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (req_bus.valid && req_bus.ready) begin
            frame_stats.take_pixel(req_bus.pixel, req_bus.last);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got_word.min_level      = rsp_bus.min_level;
            got_word.max_level      = rsp_bus.max_level;
            got_word.mean_level     = rsp_bus.mean_level;
            got_word.level_count    = rsp_bus.level_count;
            got_word.pixel_total    = rsp_bus.pixel_total;
            got_word.brightness_sum = rsp_bus.brightness_sum;
            got_word.overflow       = rsp_bus.overflow;
            frame_stats.check_frame_result(got_word);
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // receiver
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_bus.ready <= !receiver_stall();
         end
      end
   end

   task automatic send_pixel(input pixel_type p, input logic last);
      @(negedge clock);
      while (sender_gap()) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pixel <= p;
      req_bus.last  <= last;
      do @(posedge clock); while (!req_bus.ready);
      sent_words++;
   endtask

   task automatic send_frame(input int unsigned len, input int unsigned lo,
                             input int unsigned hi);
      for (int unsigned i = 0; i < len; i++)
         send_pixel(pixel_type'($urandom_range(hi, lo)), i == len - 1);
   endtask

   // every level once, in shuffled order
   task automatic send_level_sweep();
      pixel_type levels[LEVELS];
      pixel_type swap;
      int unsigned j;
      for (int i = 0; i < LEVELS; i++) levels[i] = pixel_type'(i);
      for (int i = LEVELS - 1; i > 0; i--) begin
         j = $urandom_range(i);
         swap = levels[i];
         levels[i] = levels[j];
         levels[j] = swap;
      end
      for (int i = 0; i < LEVELS; i++) send_pixel(levels[i], i == LEVELS - 1);
   endtask

   task automatic send_random_frame();
      int unsigned kind;
      int unsigned lo;
      int unsigned len;
      kind = $urandom_range(99);
      if (kind < 60) begin
         send_frame($urandom_range(16, 1), 0, 255);
      end else if (kind < 80) begin
         lo = $urandom_range(255);
         send_frame($urandom_range(40, 1), lo, (lo + 8 > 255) ? 255 : lo + 8);
      end else if (kind < 92) begin
         send_frame($urandom_range(400, 64), 0, 255);
      end else if (kind < 97) begin
         send_level_sweep();
      end else begin
         len = $urandom_range(8, 1);
         for (int unsigned i = 0; i < len; i++)
            send_pixel($urandom_range(1) ? 8'd255 : 8'd0, i == len - 1);
      end
   endtask

   initial begin
      int unsigned phase_frames;
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.pixel = '0;
      req_bus.last  = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed frames
      send_pixel(8'd0, 1'b1);
      send_pixel(8'd255, 1'b1);
      send_pixel(8'd100, 1'b0);   // first pixel must set max as well as min
      send_pixel(8'd50, 1'b1);
      send_pixel(8'd200, 1'b0);
      send_pixel(8'd100, 1'b0);
      send_pixel(8'd50, 1'b1);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd128, 1'b1);
      repeat (3) send_pixel(8'd7, 1'b0);
      send_pixel(8'd7, 1'b1);
      send_pixel(8'd1, 1'b0);     // mean truncates to 1
      send_pixel(8'd2, 1'b1);
      send_pixel(8'hAA, 1'b0);
      send_pixel(8'h55, 1'b1);

      // long receiver hold-off while short frames keep coming
      rsp_hold_req = 1'b1;
      repeat (6) send_frame($urandom_range(4, 1), 0, 255);

      sent_words = 0;
      for (int ph = IDLE_NONE; ph <= IDLE_BOTH; ph++) begin
         idle_mode = idle_mode_type'(ph);
         phase_frames = 0;
         while (sent_words < (ph + 1) * PHASE_WORDS || phase_frames < PHASE_FRAMES) begin
            send_random_frame();
            phase_frames++;
         end
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      idle_mode = IDLE_NONE;
      while (frame_stats.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (frame_stats.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/ibs_pkg.sv
hdl/ibs_channels.sv
hdl/ibs_datapath.sv
hdl/ibs_ctrl.sv
hdl/image_brightness_statistics.sv
tb/tb_image_brightness_statistics.sv
